/* hw/rtl/pes_pkg.sv */
// Package for the profile edge selector: payload structs, config indexes,
// mode codes and FSM state type. No dependencies.
package pes_pkg;

  localparam int FRAC_BITS = 8;
  localparam int ONE = 1 << FRAC_BITS;

  typedef struct packed {
    logic signed [15:0] gradient;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic        [17:0] edge_position;
    logic        [15:0] edge_strength;
    logic signed [15:0] signed_value;
    logic        [15:0] runner_up;
    logic        [9:0]  peak_total;
    logic        [9:0]  sharpness;
  } out_word_t;

  // peak entry: pos 18, strength 17, sval 16, sharp 10
  typedef struct packed {
    logic        [17:0] pos;
    logic        [16:0] strength;
    logic signed [15:0] sval;
    logic        [9:0]  sharp;
  } peak_t;

  localparam logic [2:0] CFG_ABS_FLOOR     = 3'd0;
  localparam logic [2:0] CFG_REL_FLOOR     = 3'd1;
  localparam logic [2:0] CFG_POLARITY_MODE = 3'd2;
  localparam logic [2:0] CFG_SELECT_MODE   = 3'd3;
  localparam logic [2:0] CFG_PEAK_INDEX    = 3'd4;

  localparam logic [1:0] POL_ANY = 2'd0;
  localparam logic [1:0] POL_POS = 2'd1;
  localparam logic [1:0] POL_NEG = 2'd2;

  localparam logic [2:0] SEL_STRONGEST = 3'd0;
  localparam logic [2:0] SEL_FIRST     = 3'd1;
  localparam logic [2:0] SEL_LAST      = 3'd2;
  localparam logic [2:0] SEL_MIDDLE    = 3'd3;
  localparam logic [2:0] SEL_NTH       = 3'd4;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SCAN_RD, ST_SCAN_EVAL, ST_DIV, ST_DIV_WAIT, ST_PICK_RD,
    ST_PICK, ST_RUN_RD, ST_RUN, ST_FETCH, ST_EMIT
  } state_t;

endpackage

/* hw/rtl/pes_ram.sv */
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module pes_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/pes_div.sv */
// Restoring divider, one quotient bit per cycle, rounding to nearest with
// halves away from zero on magnitudes. No dependencies.
module pes_div #(
  parameter int NW = 28,
  parameter int DW = 19
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);
  // (2*num + den) / (2*den)
  localparam int CW = $clog2(NW + 2);
  logic [NW+1:0] n;
  logic [NW+1:0] q;
  logic [DW+1:0] rem;
  logic [DW+1:0] d2;
  logic [CW-1:0] cnt;
  logic          run;
  logic [DW+2:0] trial;

  assign trial = {rem, n[NW+1]} - {1'b0, d2};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW + 2);
        n   <= {1'b0, num, 1'b0} + (NW + 2)'(den);
        d2  <= {1'b0, den, 1'b0};
        rem <= '0;
        q   <= '0;
      end else if (run) begin
        n <= n << 1;
        if (!trial[DW+2]) begin
          rem <= trial[DW+1:0];
          q   <= {q[NW:0], 1'b1};
        end else begin
          rem <= {rem[DW:0], n[NW+1]};
          q   <= {q[NW:0], 1'b0};
        end
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign quot = q[NW-1:0];
endmodule

/* hw/rtl/profile_edge_selector_top.sv */
// Profile edge selector top level: sample and peak memories, scan sequencer.
// Depends on pes_pkg, pes_ram, pes_div.
//
// Samples are taken one per cycle while loading (start high, busy low). The
// sample marked last_sample starts the end-of-profile pass, during which busy
// is high: each interior sample costs three memory reads spread over four
// read slots and one evaluate step, plus two serial divisions per peak
// (offset and sharpness, both from the shared divider), then two passes over
// the peak list, each after a read setup step, pick the edge and the
// runner-up, and a fetch step reads out the chosen entry. One result word
// appears on the result ports with result_valid high for exactly one cycle
// at the end; the receiver cannot stall it.
// Samples past MAX_SAMPLES are dropped but a last_sample mark still ends the
// profile. Memories need no clearing after reset.
module profile_edge_selector_top #(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pes_pkg::in_word_t  in_word,
  output logic               result_valid,
  output pes_pkg::out_word_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  localparam int AW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  // configuration registers
  logic [15:0] abs_floor, rel_floor;
  logic [1:0]  polarity_mode;
  logic [2:0]  select_mode;
  logic [9:0]  peak_index;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      abs_floor <= '0; rel_floor <= '0; polarity_mode <= '0;
      select_mode <= '0; peak_index <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pes_pkg::CFG_ABS_FLOOR:     abs_floor     <= cfg_data;
        pes_pkg::CFG_REL_FLOOR:     rel_floor     <= cfg_data;
        pes_pkg::CFG_POLARITY_MODE: polarity_mode <= cfg_data[1:0];
        pes_pkg::CFG_SELECT_MODE:   select_mode   <= cfg_data[2:0];
        pes_pkg::CFG_PEAK_INDEX:    peak_index    <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  pes_pkg::state_t state, state_next;

  // control registers
  logic [CW-1:0] sample_count, peak_count, idx, sel;
  logic [16:0]   max_magnitude;
  logic [1:0]    phase;            // read slot within scan of one sample
  logic [16:0]   mag_a, mag_b, mag_c;
  logic signed [15:0] g_b;
  logic [16:0]   best, runner;
  logic          div_sel;          // 0 offset, 1 sharpness
  logic signed [9:0] delta;

  logic accept;
  assign accept = start && !busy;
  assign busy = (state != pes_pkg::ST_LOAD);

  // sample memory
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [15:0]   s_rdata;
  pes_ram #(.WIDTH(16), .DEPTH(MAX_SAMPLES)) u_samples (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(in_word.gradient),
    .raddr(s_raddr), .rdata(s_rdata));
  assign s_we = accept && (sample_count < CW'(MAX_SAMPLES));
  assign s_waddr = sample_count[AW-1:0];

  // peak memory
  logic          p_we;
  logic [AW-1:0] p_raddr;
  pes_pkg::peak_t p_wdata, p_rdata;
  pes_ram #(.WIDTH($bits(pes_pkg::peak_t)), .DEPTH(MAX_SAMPLES)) u_peaks (
    .clk(clk), .we(p_we), .waddr(peak_count[AW-1:0]), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata));

  // magnitude of a sample word
  function automatic logic [16:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? 17'(-{v[15], v}) : {1'b0, v};
  endfunction

  // peak test on registered a,b,c
  logic pol_ok, shape_ok, floor_ok, is_peak;
  logic [17:0] curv;
  logic [33:0] lhs, rhs;
  always_comb begin
    pol_ok = !((polarity_mode == pes_pkg::POL_POS && (g_b[15] || g_b == 16'sd0)) ||
               (polarity_mode == pes_pkg::POL_NEG && !g_b[15]));
    shape_ok = mag_b >= mag_a && mag_b >= mag_c && (mag_b > mag_a || mag_b > mag_c);
    lhs = {mag_b, 17'd0} >> 2;     // b*32768
    rhs = 34'(rel_floor) * 34'(max_magnitude);
    floor_ok = (mag_b > {1'b0, abs_floor}) && (lhs > rhs);
    is_peak = pol_ok && shape_ok && floor_ok;
    curv = {mag_b, 1'b0} - 18'(mag_a) - 18'(mag_c);
  end

  // shared divider
  logic        div_start, div_done;
  logic [27:0] div_num, div_quot;
  logic [18:0] div_den;
  logic [17:0] cma;
  logic        cneg;
  assign cneg = mag_c < mag_a;
  assign cma = cneg ? 18'(mag_a - mag_c) : 18'(mag_c - mag_a);
  always_comb begin
    if (!div_sel) begin
      div_num = 28'(cma) << pes_pkg::FRAC_BITS;
      div_den = {curv, 1'b0};
    end else begin
      div_num = 28'(curv) << pes_pkg::FRAC_BITS;
      div_den = 19'(mag_b);
    end
  end
  pes_div #(.NW(28), .DW(19)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot));

  logic [9:0] delta_mag;
  assign delta_mag = (div_quot > 28'(pes_pkg::ONE)) ? 10'(pes_pkg::ONE) : div_quot[9:0];

  always_comb begin
    p_wdata.pos = 18'(({8'd0, idx} << pes_pkg::FRAC_BITS) + {{9{delta[9]}}, delta});
    p_wdata.strength = mag_b;
    p_wdata.sval = g_b;
    p_wdata.sharp = div_quot[9:0];
  end

  // next state
  logic scan_ok;
  assign scan_ok = sample_count >= CW'(3) && max_magnitude != '0;
  always_comb begin
    state_next = state;
    unique case (state)
      pes_pkg::ST_LOAD:
        if (accept && in_word.last_sample)
          state_next = scan_ok || (s_we && sample_count >= CW'(2) &&
                       (max_magnitude != '0 || mag16(in_word.gradient) != '0))
                       ? pes_pkg::ST_SCAN_RD : pes_pkg::ST_EMIT;
      pes_pkg::ST_SCAN_RD:
        state_next = (phase == 2'd3) ? pes_pkg::ST_SCAN_EVAL : pes_pkg::ST_SCAN_RD;
      pes_pkg::ST_SCAN_EVAL:
        if (is_peak) state_next = pes_pkg::ST_DIV;
        else if (idx + CW'(2) >= sample_count) state_next = pes_pkg::ST_PICK_RD;
        else state_next = pes_pkg::ST_SCAN_RD;
      pes_pkg::ST_DIV: state_next = pes_pkg::ST_DIV_WAIT;
      pes_pkg::ST_DIV_WAIT:
        if (div_done && div_sel)
          state_next = (idx + CW'(2) >= sample_count) ? pes_pkg::ST_PICK_RD
                                                      : pes_pkg::ST_SCAN_RD;
        else if (div_done) state_next = pes_pkg::ST_DIV;
      pes_pkg::ST_PICK_RD:
        state_next = (peak_count == '0) ? pes_pkg::ST_EMIT : pes_pkg::ST_PICK;
      pes_pkg::ST_PICK:
        state_next = (idx + CW'(1) >= peak_count) ? pes_pkg::ST_RUN_RD
                                                  : pes_pkg::ST_PICK;
      pes_pkg::ST_RUN_RD: state_next = pes_pkg::ST_RUN;
      pes_pkg::ST_RUN:
        state_next = (idx + CW'(1) >= peak_count) ? pes_pkg::ST_FETCH
                                                  : pes_pkg::ST_RUN;
      pes_pkg::ST_FETCH: state_next = pes_pkg::ST_EMIT;
      pes_pkg::ST_EMIT: state_next = pes_pkg::ST_LOAD;
      default: state_next = pes_pkg::ST_LOAD;
    endcase
  end

  // outputs / memory control
  always_comb begin
    s_raddr = idx[AW-1:0];
    if (state == pes_pkg::ST_SCAN_RD)
      s_raddr = AW'(idx - CW'(1) + CW'(phase));
    p_raddr = idx[AW-1:0];
    if (state == pes_pkg::ST_PICK || state == pes_pkg::ST_RUN)
      p_raddr = AW'(idx + CW'(1));
    if (state == pes_pkg::ST_PICK_RD || state == pes_pkg::ST_RUN_RD)
      p_raddr = '0;
    if (state == pes_pkg::ST_FETCH) p_raddr = sel[AW-1:0];
    div_start = (state == pes_pkg::ST_DIV);
    p_we = (state == pes_pkg::ST_DIV_WAIT) && div_done && div_sel;
  end

  logic [CW-1:0] nth;
  assign nth = (CW'(peak_index) < peak_count) ? CW'(peak_index) : peak_count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pes_pkg::ST_LOAD;
      sample_count <= '0; max_magnitude <= '0; peak_count <= '0;
      idx <= '0; phase <= '0; div_sel <= 1'b0; result_valid <= 1'b0;
    end else begin
      state <= state_next;
      result_valid <= 1'b0;
      unique case (state)
        pes_pkg::ST_LOAD: begin
          if (s_we) begin
            sample_count <= sample_count + CW'(1);
            if (mag16(in_word.gradient) > max_magnitude)
              max_magnitude <= mag16(in_word.gradient);
          end
          idx <= CW'(1); phase <= '0; peak_count <= '0;
        end
        pes_pkg::ST_SCAN_RD: begin
          phase <= phase + 2'd1;
          if (phase == 2'd1) mag_a <= mag16(s_rdata);
          if (phase == 2'd2) begin mag_b <= mag16(s_rdata); g_b <= s_rdata; end
          if (phase == 2'd3) mag_c <= mag16(s_rdata);
        end
        pes_pkg::ST_SCAN_EVAL: begin
          phase <= '0; div_sel <= 1'b0;
          if (!is_peak) idx <= idx + CW'(1);
          if (!is_peak && idx + CW'(2) >= sample_count) idx <= '0;
        end
        pes_pkg::ST_DIV_WAIT:
          if (div_done && !div_sel) begin
            delta <= cneg ? -$signed(delta_mag) : $signed(delta_mag);
            div_sel <= 1'b1;
          end else if (div_done) begin
            peak_count <= peak_count + CW'(1);
            idx <= (idx + CW'(2) >= sample_count) ? '0 : idx + CW'(1);
          end
        pes_pkg::ST_PICK_RD: begin
          idx <= '0; best <= '0; runner <= '0;
          unique case (select_mode)
            pes_pkg::SEL_FIRST:  sel <= '0;
            pes_pkg::SEL_LAST:   sel <= peak_count - CW'(1);
            pes_pkg::SEL_MIDDLE: sel <= peak_count >> 1;
            pes_pkg::SEL_NTH:    sel <= nth;
            default:             sel <= '0;
          endcase
        end
        pes_pkg::ST_PICK: begin
          idx <= idx + CW'(1);
          if (select_mode == pes_pkg::SEL_STRONGEST || select_mode > pes_pkg::SEL_NTH) begin
            if (idx == '0 || p_rdata.strength > best) begin
              best <= p_rdata.strength; sel <= idx;
            end
          end
          if (idx + CW'(1) >= peak_count) idx <= '0;
        end
        pes_pkg::ST_RUN: begin
          idx <= idx + CW'(1);
          if (idx != sel && p_rdata.strength > runner) runner <= p_rdata.strength;
        end
        pes_pkg::ST_EMIT: begin
          result_valid <= 1'b1;
          sample_count <= '0; max_magnitude <= '0; peak_count <= '0;
        end
        default: ;
      endcase
    end
  end

  // result word, zero when nothing found; the selected entry is read out
  // during FETCH and lands on p_rdata in EMIT
  always_ff @(posedge clk) begin
    if (state == pes_pkg::ST_LOAD) result <= '0;
    if (state == pes_pkg::ST_EMIT && peak_count != '0) begin
      result.found         <= 1'b1;
      result.edge_position <= p_rdata.pos;
      result.edge_strength <= p_rdata.strength[15:0];
      result.signed_value  <= p_rdata.sval;
      result.runner_up     <= runner[15:0];
      result.peak_total    <= peak_count[9:0];
      result.sharpness     <= p_rdata.sharp;
    end
  end

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state) == pes_pkg::ST_EMIT) else $error("stray result");
  a_one_shot: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid) else $error("double result");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CW'(MAX_SAMPLES)) else $error("sample count overflow");
  a_peak_le: assert property (@(posedge clk) disable iff (rst)
    peak_count <= sample_count) else $error("peak count too large");
endmodule
